@@ rtl/risqm_pkg.sv @@
// shared constants for the rotation invariant square match block
// no dependencies; imported by rotation_invariant_square_match
`default_nettype none

package risqm_pkg;

	localparam int MAX_SIDE_DEF = 16;
	localparam int PIX_W        = 8;
	localparam int COUNT_W      = 16;
	localparam int DIM_W        = 5;
	localparam int NUM_ROT      = 4;

	localparam logic [DIM_W-1:0]   DIM_RESET = DIM_W'(16);
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [NUM_ROT-1:0] FLAGS_ALL = '1;

	// operation codes carried on tuser
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_FIGURE = 1'b1;

	// output tdata layout
	localparam int OUT_DATA_W = ((1 + COUNT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

@@ rtl/rotation_invariant_square_match.sv @@
// top level of the rotation invariant square match block
// depends on risqm_pkg; holds four replicated copies of the reference image
//
// usage
//  - the input stream carries one pixel per transaction in row-major order;
//    tuser says whether the pixel loads the reference image or belongs to a
//    candidate figure; reference and figures share one position counter
//  - the configuration port writes the side length; a write returns the
//    position to the top-left corner and abandons any partial image
//  - every pixel of a figure is compared with four reference pixels at once,
//    one per quarter turn, each read from its own copy of the reference
//    memory; the copies are written together on every reference load
//  - after the last pixel of a figure one output transaction reports whether
//    any rotation matched and the saturating count of matching figures
//  - throughput: one pixel per clock while s_axis_tready is high, set by the
//    single read port of each reference copy; the figure's last pixel passes
//    through stage 1 and then the output register before the result is valid
//  - when the output is stalled the finished result waits in the output
//    register; the stage behind it keeps taking pixels until a second result
//    would need that register, and only then is s_axis_tready dropped
//  - reset clears position, rotation flags, count and the pipeline; the
//    reference image itself is undefined until loaded
`default_nettype none

module rotation_invariant_square_match #(
	parameter int MAX_SIDE = risqm_pkg::MAX_SIDE_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration: side length
	input  wire logic                          cfg_wen,
	input  wire logic [risqm_pkg::DIM_W-1:0]   cfg_wdata,
	// input stream
	input  wire logic                          s_axis_tvalid,
	output      logic                          s_axis_tready,
	input  wire logic [risqm_pkg::PIX_W-1:0]   s_axis_tdata,  // pixel_value
	input  wire logic                          s_axis_tuser,  // operation
	// result stream
	output      logic                          m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output      logic [risqm_pkg::OUT_DATA_W-1:0] m_axis_tdata // figure_matches, match_count, zero pad
);

	import risqm_pkg::*;

	localparam int IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int CMP_W  = (SIDE_W > DIM_W) ? SIDE_W : DIM_W;
	localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// row-major address of a reference pixel
	function automatic logic [ADDR_W-1:0] pix_addr(input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c);
		pix_addr = ADDR_W'(r) * ADDR_W'(MAX_SIDE) + ADDR_W'(c);
	endfunction

	// configuration and position state
	logic [DIM_W-1:0]   dim_q;
	logic [IDX_W-1:0]   row_q;
	logic [IDX_W-1:0]   col_q;
	logic [NUM_ROT-1:0] flags_q;
	logic [COUNT_W-1:0] count_q;

	// stage 1: memory read data and the item that asked for it
	logic               valid_s1;
	logic               op_s1;
	logic               last_s1;
	logic [PIX_W-1:0]   pix_s1;
	logic [PIX_W-1:0]   rd_s1 [NUM_ROT];

	// output register
	logic               out_valid_q;
	logic               out_hit_q;
	logic [COUNT_W-1:0] out_count_q;

	// replicated reference memory, one read port per rotation
	logic [PIX_W-1:0]   ref_mem [NUM_ROT][DEPTH];

	logic               in_accept;
	logic               s1_result;
	logic               s1_advance;
	logic [SIDE_W-1:0]  side;
	logic [IDX_W-1:0]   last_idx;
	logic [IDX_W-1:0]   pos_a;
	logic [IDX_W-1:0]   pos_b;
	logic [IDX_W-1:0]   inv_a;
	logic [IDX_W-1:0]   inv_b;
	logic [IDX_W-1:0]   row_nxt;
	logic [IDX_W-1:0]   col_nxt;
	logic               wrap;
	logic [ADDR_W-1:0]  rd_addr [NUM_ROT];
	logic               mem_wr;
	logic               mem_rd;
	logic [NUM_ROT-1:0] miss;
	logic [NUM_ROT-1:0] flags_nxt;
	logic               hit;
	logic [COUNT_W-1:0] count_nxt;

	// side length in use, clamped to 1..MAX_SIDE
	always_comb begin
		if (CMP_W'(dim_q) == '0) begin
			side = SIDE_W'(1);
		end else if (CMP_W'(dim_q) > CMP_W'(MAX_SIDE)) begin
			side = SIDE_W'(MAX_SIDE);
		end else begin
			side = SIDE_W'(dim_q);
		end
	end

	assign last_idx = IDX_W'(side - SIDE_W'(1));

	// position guard and advance
	always_comb begin
		if (SIDE_W'(row_q) >= side || SIDE_W'(col_q) >= side) begin
			pos_a = '0;
			pos_b = '0;
		end else begin
			pos_a = row_q;
			pos_b = col_q;
		end
		inv_a = last_idx - pos_a;
		inv_b = last_idx - pos_b;
		wrap  = 1'b0;
		if (pos_b == last_idx) begin
			col_nxt = '0;
			if (pos_a == last_idx) begin
				row_nxt = '0;
				wrap    = 1'b1;
			end else begin
				row_nxt = pos_a + IDX_W'(1);
			end
		end else begin
			col_nxt = pos_b + IDX_W'(1);
			row_nxt = pos_a;
		end
	end

	// one address per quarter turn: (a,b) (b,m-a) (m-a,m-b) (m-b,a)
	assign rd_addr[0] = pix_addr(pos_a, pos_b);
	assign rd_addr[1] = pix_addr(pos_b, inv_a);
	assign rd_addr[2] = pix_addr(inv_a, inv_b);
	assign rd_addr[3] = pix_addr(inv_b, pos_a);

	// handshake: stage 1 only waits when it holds a result and the
	// output register is still occupied
	assign s1_result     = valid_s1 && (op_s1 == OP_FIGURE) && last_s1;
	assign s1_advance    = !s1_result || !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || s1_advance;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	assign mem_wr = in_accept && (s_axis_tuser == OP_LOAD);
	assign mem_rd = in_accept && (s_axis_tuser == OP_FIGURE);

	// reference copies: all written together, each read at its own address
	always_ff @(posedge clk) begin
		for (int r = 0; r < NUM_ROT; r++) begin
			if (mem_wr) begin
				ref_mem[r][rd_addr[0]] <= s_axis_tdata;
			end
			if (mem_rd) begin
				rd_s1[r] <= ref_mem[r][rd_addr[r]];
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1   <= s_axis_tuser;
			last_s1 <= wrap;
			pix_s1  <= s_axis_tdata;
		end
	end

	// compare and flag update
	always_comb begin
		for (int r = 0; r < NUM_ROT; r++) begin
			miss[r] = (rd_s1[r] != pix_s1);
		end
		flags_nxt = flags_q & ~miss;
		hit       = |flags_nxt;
		if (hit && count_q != COUNT_MAX) begin
			count_nxt = count_q + COUNT_W'(1);
		end else begin
			count_nxt = count_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q       <= DIM_RESET;
			row_q       <= '0;
			col_q       <= '0;
			flags_q     <= FLAGS_ALL;
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (s1_advance) begin
				valid_s1 <= in_accept;
			end
			if (in_accept) begin
				row_q <= row_nxt;
				col_q <= col_nxt;
			end
			if (valid_s1 && s1_advance) begin
				if (op_s1 == OP_LOAD) begin
					flags_q <= FLAGS_ALL;
				end else if (last_s1) begin
					flags_q     <= FLAGS_ALL;
					count_q     <= count_nxt;
					out_valid_q <= 1'b1;
				end else begin
					flags_q <= flags_nxt;
				end
			end
			if (cfg_wen) begin
				dim_q   <= cfg_wdata;
				row_q   <= '0;
				col_q   <= '0;
				flags_q <= FLAGS_ALL;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (s1_result && s1_advance) begin
			out_hit_q   <= hit;
			out_count_q <= count_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'({out_count_q, out_hit_q});

	// input only stalls behind a finished result that cannot move on
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && out_valid_q && !m_axis_tready)
		else $error("input stalled without a blocked result");

	// the match count never goes down
	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q >= $past(count_q))
		else $error("match count decreased");

	// a reported match always carries a nonzero count
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_hit_q |-> out_count_q != '0)
		else $error("match reported with zero count");

	// a fresh result leaves the rotation flags rearmed for the next figure
	a_flags_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> flags_q == FLAGS_ALL)
		else $error("rotation flags not rearmed after a figure");

	// position stays inside the largest image
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		SIDE_W'(row_q) < SIDE_W'(MAX_SIDE) && SIDE_W'(col_q) < SIDE_W'(MAX_SIDE))
		else $error("position outside the image");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// self-checking bench for rotation_invariant_square_match: streams reference and figure pixels,
// predicts each match verdict and running count, and compares every output transaction
// depends on risqm_pkg and the rotation_invariant_square_match rtl only
`timescale 1ns / 1ps

module tb_top;
	import risqm_pkg::*;

	localparam int SIDE_MAX     = MAX_SIDE_DEF;
	localparam int SETTLE_EDGES = 4;     // margin for the result to pass stage 1 and the output register
	localparam int QUIET_LIMIT  = 2000;  // cycles without any transaction before giving up
	localparam int RANDOM_ITEMS = 400;
	localparam int RANDOM_VERDICTS = 40;

	typedef struct packed {
		logic               hit;
		logic [COUNT_W-1:0] count;
	} verdict_t;

	typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_t;
	typedef enum {FIG_TURNED, FIG_FLAWED, FIG_RANDOM} fig_kind_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wen = 1'b0;
	logic [DIM_W-1:0]      cfg_wdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [PIX_W-1:0]      s_axis_tdata = '0;   // pixel_value
	logic                  s_axis_tuser = 1'b0; // operation
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // figure_matches, match_count, zero pad

	// predictor state: reference copy, side register, shared position, turn flags, count
	logic [PIX_W-1:0]   ref_pixels [SIDE_MAX][SIDE_MAX];
	logic [DIM_W-1:0]   side_reg = DIM_RESET;
	int                 pos_row = 0;
	int                 pos_col = 0;
	logic [NUM_ROT-1:0] turn_alive = FLAGS_ALL;
	logic [COUNT_W-1:0] figure_hits = '0;
	verdict_t           pending_verdicts [$];

	// stimulus knobs and bookkeeping
	bit        sender_gaps = 1'b0;
	int        burst_left = 0;
	rx_style_t rx_style = RX_ALWAYS;
	int        rx_phase = 0;
	int        pix_span = 255;
	int        pixels_sent = 0;
	int        verdicts_checked = 0;
	int        mismatches = 0;
	int        quiet_cycles = 0;

	rotation_invariant_square_match u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	// side length actually in use, register clamped to 1..SIDE_MAX
	function automatic int side_in_use();
		if (side_reg == '0)
			return 1;
		if (int'(side_reg) > SIDE_MAX)
			return SIDE_MAX;
		return int'(side_reg);
	endfunction

	// row-major advance; returns 1 when the image wraps to the corner
	function automatic bit step_position(input int n);
		pos_col++;
		if (pos_col >= n) begin
			pos_col = 0;
			pos_row++;
			if (pos_row >= n) begin
				pos_row = 0;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// pixel a figure needs at (a,b) to equal the reference after the given quarter turns
	function automatic logic [PIX_W-1:0] turned_pixel(input int turn, input int a, input int b);
		int m;
		m = side_in_use() - 1;
		case (turn)
			0: return ref_pixels[a][b];
			1: return ref_pixels[b][m-a];
			2: return ref_pixels[m-a][m-b];
			default: return ref_pixels[m-b][a];
		endcase
	endfunction

	// applies one accepted pixel; queues a verdict when a figure completes
	function automatic void predict_pixel(input logic op, input logic [PIX_W-1:0] px);
		int n;
		int a;
		int b;
		int m;
		verdict_t v;
		n = side_in_use();
		if (pos_row >= n || pos_col >= n) begin
			pos_row = 0;
			pos_col = 0;
		end
		a = pos_row;
		b = pos_col;
		m = n - 1;
		if (op == OP_LOAD) begin
			ref_pixels[a][b] = px;
			turn_alive = FLAGS_ALL;
			void'(step_position(n));
		end else begin
			if (ref_pixels[a][b] != px)
				turn_alive[0] = 1'b0;
			if (ref_pixels[b][m-a] != px)
				turn_alive[1] = 1'b0;
			if (ref_pixels[m-a][m-b] != px)
				turn_alive[2] = 1'b0;
			if (ref_pixels[m-b][a] != px)
				turn_alive[3] = 1'b0;
			if (step_position(n)) begin
				v.hit = |turn_alive;
				if (v.hit && figure_hits != COUNT_MAX)
					figure_hits++;
				v.count = figure_hits;
				turn_alive = FLAGS_ALL;
				pending_verdicts.push_back(v);
			end
		end
	endfunction

	// ---------------------------------------------------------------
	// drivers
	// ---------------------------------------------------------------

	// one input transaction; bursts of random length, separated by random gaps when sender_gaps is set
	task automatic send_pixel(input logic op, input logic [PIX_W-1:0] px);
		if (burst_left == 0) begin
			if (sender_gaps) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= px;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pixels_sent++;
		predict_pixel(op, px);
	endtask

	// drop valid, wait for every verdict, then let the pipeline empty
	task automatic settle_block();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_EDGES) @(posedge clk);
	endtask

	// side length write, only once the block is idle
	task automatic write_side(input logic [DIM_W-1:0] value);
		settle_block();
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		side_reg   = value;
		pos_row    = 0;
		pos_col    = 0;
		turn_alive = FLAGS_ALL;
	endtask

	// loads the reference from the current position up to the wrap
	task automatic send_reference();
		int n;
		int left;
		n = side_in_use();
		left = n * n - (pos_row * n + pos_col);
		repeat (left)
			send_pixel(OP_LOAD, PIX_W'($urandom_range(0, pix_span)));
	endtask

	// figure pixels from the current position up to the wrap
	task automatic send_figure(input fig_kind_t kind, input int turn);
		int n;
		int left;
		int flaw_at;
		logic [PIX_W-1:0] px;
		n = side_in_use();
		left = n * n - (pos_row * n + pos_col);
		flaw_at = $urandom_range(0, left - 1);
		for (int k = 0; k < left; k++) begin
			if (kind == FIG_RANDOM)
				px = PIX_W'($urandom_range(0, pix_span));
			else
				px = turned_pixel(turn, pos_row, pos_col);
			if (kind == FIG_FLAWED && k == flaw_at)
				px ^= PIX_W'($urandom_range(1, 255));
			send_pixel(OP_FIGURE, px);
		end
	endtask

	// receiver stalls: always ready, coin flips, or a fixed duty pattern
	always @(posedge clk) begin
		rx_phase <= rx_phase + 1;
		case (rx_style)
			RX_ALWAYS: m_axis_tready <= 1'b1;
			RX_RANDOM: m_axis_tready <= ($urandom_range(0, 99) < 65);
			default:   m_axis_tready <= ((rx_phase % 11) < 7);
		endcase
	end

	// ---------------------------------------------------------------
	// checking
	// ---------------------------------------------------------------

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t ERROR %s", $time, what);
	endtask

	// every output transaction against the oldest queued verdict
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			verdicts_checked++;
			if (pending_verdicts.size() == 0) begin
				report_mismatch($sformatf("unexpected result data %h", m_axis_tdata));
			end else begin
				want = pending_verdicts.pop_front();
				if (m_axis_tdata[0] !== want.hit)
					report_mismatch($sformatf("figure_matches %b, predicted %b",
						m_axis_tdata[0], want.hit));
				if (m_axis_tdata[COUNT_W:1] !== want.count)
					report_mismatch($sformatf("match_count %0d, predicted %0d",
						m_axis_tdata[COUNT_W:1], want.count));
			end
		end
	end

	// watchdog: no transaction on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("rotation_invariant_square_match: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// out-of-range side clamps to the full size; whole reference, one turned figure
	task automatic test_full_side();
		sender_gaps = 1'b1;
		rx_style    = RX_RANDOM;
		pix_span    = 255;
		write_side(DIM_W'(31));
		send_reference();
		send_figure(FIG_TURNED, 2);
	endtask

	// side zero runs as a one pixel image; pixel extremes
	task automatic test_single_pixel();
		sender_gaps = 1'b0;
		rx_style    = RX_PATTERN;
		write_side('0);
		send_pixel(OP_LOAD, 8'hFF);
		send_pixel(OP_FIGURE, 8'hFF);
		send_pixel(OP_FIGURE, 8'hFE);
		send_pixel(OP_LOAD, 8'h00);
		send_pixel(OP_FIGURE, 8'h00);
	endtask

	// 2x2 reference with distinct corners, odd quarter turns and a broken figure
	task automatic test_quarter_turns();
		write_side(DIM_W'(2));
		send_pixel(OP_LOAD, 8'h00);
		send_pixel(OP_LOAD, 8'hFF);
		send_pixel(OP_LOAD, 8'h80);
		send_pixel(OP_LOAD, 8'h7F);
		send_figure(FIG_TURNED, 1);
		send_figure(FIG_TURNED, 3);
		send_figure(FIG_FLAWED, 0);
	endtask

	// side write in mid figure drops the partial figure and its flags
	task automatic test_abandoned_figure();
		send_pixel(OP_FIGURE, 8'h11);
		send_pixel(OP_FIGURE, turned_pixel(0, pos_row, pos_col));
		write_side(DIM_W'(2));
		send_figure(FIG_TURNED, 2);
	endtask

	// phases of random side, reference and mostly well-formed figures mixed with noise
	task automatic test_random_traffic();
		int first_pixel;
		int first_verdict;
		int pick;
		int n;
		first_pixel   = pixels_sent;
		first_verdict = verdicts_checked + pending_verdicts.size();
		while (pixels_sent - first_pixel < RANDOM_ITEMS ||
				verdicts_checked + pending_verdicts.size() - first_verdict < RANDOM_VERDICTS) begin
			sender_gaps = ($urandom_range(0, 3) != 0);
			rx_style    = rx_style_t'($urandom_range(0, 2));
			pix_span    = ($urandom_range(0, 3) == 0) ? 1 : 255;
			pick = $urandom_range(0, 99);
			if (pick < 8)
				write_side('0);
			else if (pick < 16)
				write_side(DIM_W'(1));
			else if (pick < 80)
				write_side(DIM_W'($urandom_range(2, 4)));
			else
				write_side(DIM_W'($urandom_range(5, 7)));
			if ($urandom_range(0, 2) != 0)
				send_reference();
			repeat ($urandom_range(2, 6)) begin
				pick = $urandom_range(0, 99);
				n = side_in_use();
				if (pick < 55) begin
					send_figure(FIG_TURNED, $urandom_range(0, 3));
				end else if (pick < 70) begin
					send_figure(FIG_FLAWED, $urandom_range(0, 3));
				end else if (pick < 82) begin
					send_figure(FIG_RANDOM, 0);
				end else begin
					// mixed loads and figure pixels, leaving the shared position anywhere
					repeat ($urandom_range(1, 2 * n * n))
						send_pixel(logic'($urandom_range(0, 1)),
							PIX_W'($urandom_range(0, pix_span)));
				end
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_full_side();
		test_single_pixel();
		test_quarter_turns();
		test_abandoned_figure();
		test_random_traffic();

		settle_block();
		if (mismatches == 0 && pending_verdicts.size() == 0)
			$display("rotation_invariant_square_match: match");
		else
			$display("rotation_invariant_square_match: mismatch");
		$finish;
	end

endmodule

@@ rotation_invariant_square_match.f @@
rtl/risqm_pkg.sv
rtl/rotation_invariant_square_match.sv
bench/tb_top.sv
